/* design/albf_pkg.sv */
// Shared types and constants for the lidar angular bin fusion block.
// No dependencies; the files that use it refer to this package by scoped name.
`timescale 1ns / 1ps

package albf_pkg;

    // One full turn in 1/64 degree units
    localparam int TURN_UNITS = 23040;

    // Field widths
    localparam int ANGLE_W   = 15;
    localparam int DIST_W    = 16;
    localparam int INTEN_W   = 16;
    localparam int COUNT_W   = 11;
    localparam int OUT_BIN_W = 10;
    localparam int IN_BIN_W  = 10;
    localparam int STATUS_W  = 3;

    // Bin divider: numerator 2*rel+step, denominator 2*step, two quotient bits a cycle
    localparam int NUM_W     = 17;
    localparam int DEN_W     = 16;
    localparam int Q_W       = 16;
    localparam int DIV_STEPS = Q_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int DS_W      = DEN_W + Q_W - 2;

    // Configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH  = 3'd5;

    // Register values after reset
    localparam logic [ANGLE_W-1:0] ANGLE_LOW_RST   = 15'd0;
    localparam logic [ANGLE_W-1:0] ANGLE_HIGH_RST  = 15'd23039;
    localparam logic [ANGLE_W-1:0] ANGLE_STEP_RST  = 15'd23;
    localparam logic [COUNT_W-1:0] BINS_IN_USE_RST = 11'd1002;
    localparam logic [DIST_W-1:0]  RANGE_LOW_RST   = 16'd0;
    localparam logic [DIST_W-1:0]  RANGE_HIGH_RST  = 16'd65535;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_NEW       = 3'd0,
        ST_CLOSER    = 3'd1,
        ST_KEPT      = 3'd2,
        ST_RANGE_OUT = 3'd3,
        ST_ANGLE_OUT = 3'd4,
        ST_BIN_OUT   = 3'd5,
        ST_READ      = 3'd6
    } status_t;

    // What the back end has to do with a queued command
    typedef enum logic [1:0] {
        CMD_ADD,
        CMD_READ,
        CMD_REJECT
    } cmd_kind_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle_low;
        logic [ANGLE_W-1:0] angle_high;
        logic [ANGLE_W-1:0] angle_step;
        logic [COUNT_W-1:0] bins_in_use;
        logic [DIST_W-1:0]  range_low_mm;
        logic [DIST_W-1:0]  range_high_mm;
    } cfg_t;

    typedef struct packed {
        cmd_kind_t          kind;
        status_t            reject;
        logic [Q_W-1:0]     bin;
        logic               hit;
        logic [DIST_W-1:0]  dist_mm;
        logic [INTEN_W-1:0] inten;
    } cmd_t;

    typedef struct packed {
        status_t              status;
        logic [OUT_BIN_W-1:0] bin_number;
        logic                 filled;
        logic [DIST_W-1:0]    rng_mm;
        logic [INTEN_W-1:0]   inten;
    } res_t;

    // One bin store entry
    typedef struct packed {
        logic               valid;
        logic [DIST_W-1:0]  rng_mm;
        logic [INTEN_W-1:0] inten;
    } entry_t;

endpackage

/* design/albf_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module albf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

/* design/albf_fifo.sv */
// Two-entry queue used between the front and back ends and on the result side.
// No dependencies.
`timescale 1ns / 1ps

module albf_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int DEPTH   = 2;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = count_reg == COUNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Storage for waiting beats
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

/* design/albf_front.sv */
// Front end: accepts input beats, wraps and gates the angle, divides out the bin.
// Depends on albf_pkg; feeds commands to the back end through a queue.
`timescale 1ns / 1ps

module albf_front #(
    parameter int BIN_DEPTH = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  albf_pkg::cfg_t                       cfg,
    input  logic                                 clearing,
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 func,
    input  logic signed [15:0]                   point_angle,
    input  logic [albf_pkg::DIST_W-1:0]          point_distance_mm,
    input  logic [albf_pkg::INTEN_W-1:0]         point_intensity,
    input  logic [albf_pkg::IN_BIN_W-1:0]        read_bin,
    output logic                                 cmd_push,
    output albf_pkg::cmd_t                       cmd,
    input  logic                                 cmd_full
);

    localparam int W_DIV = albf_pkg::DS_W + 1;
    localparam logic signed [16:0] TURN = 17'(albf_pkg::TURN_UNITS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_GATE,
        S_DIV,
        S_SEND
    } state_t;

    state_t                              state_reg;
    logic                                func_reg;
    logic [albf_pkg::ANGLE_W-1:0]        ang_reg;
    logic [albf_pkg::DIST_W-1:0]         dist_reg;
    logic [albf_pkg::INTEN_W-1:0]        inten_reg;
    logic [albf_pkg::IN_BIN_W-1:0]       rbin_reg;
    albf_pkg::cmd_kind_t                 kind_reg;
    albf_pkg::status_t                   rej_reg;
    logic [albf_pkg::NUM_W-1:0]          rem_reg;
    logic [albf_pkg::DS_W-1:0]           ds_reg;
    logic [albf_pkg::Q_W-1:0]            q_reg;
    logic [albf_pkg::DIV_CNT_W-1:0]      cnt_reg;

    logic signed [16:0]                  a_ext;
    logic signed [16:0]                  a_wrap;
    logic                                range_out;
    logic                                angle_out;
    logic                                step_zero;
    logic [albf_pkg::ANGLE_W-1:0]        rel;
    logic [albf_pkg::NUM_W-1:0]          num;
    logic [albf_pkg::DEN_W-1:0]          den;
    logic [W_DIV-1:0]                    r0;
    logic [W_DIV-1:0]                    r1;
    logic [W_DIV-1:0]                    r2;
    logic                                b1;
    logic                                b0;
    logic [albf_pkg::NUM_W-1:0]          rem_next;
    logic [albf_pkg::Q_W-1:0]            q_next;
    logic [albf_pkg::DS_W-1:0]           ds_next;
    logic                                bin_over;

    assign full = (state_reg != S_IDLE) || clearing;

    // Wrap the signed angle into one turn
    assign a_ext = 17'(point_angle);

    always_comb
    begin
        if (a_ext < -TURN)
        begin
            a_wrap = a_ext + TURN + TURN;
        end
        else if (a_ext < 0)
        begin
            a_wrap = a_ext + TURN;
        end
        else if (a_ext >= TURN)
        begin
            a_wrap = a_ext - TURN;
        end
        else
        begin
            a_wrap = a_ext;
        end
    end

    // Gates, then numerator and denominator of the rounded bin division
    assign range_out = (dist_reg < cfg.range_low_mm) || (dist_reg > cfg.range_high_mm);
    assign angle_out = (ang_reg < cfg.angle_low) || (ang_reg > cfg.angle_high);
    assign step_zero = cfg.angle_step == '0;
    assign rel       = ang_reg - cfg.angle_low;
    assign num       = albf_pkg::NUM_W'({rel, 1'b0}) + albf_pkg::NUM_W'(cfg.angle_step);
    assign den       = {cfg.angle_step, 1'b0};

    // Restoring divider, two quotient bits per cycle
    always_comb
    begin
        r0       = W_DIV'(rem_reg);
        b1       = r0 >= {ds_reg, 1'b0};
        r1       = b1 ? (r0 - {ds_reg, 1'b0}) : r0;
        b0       = r1 >= W_DIV'(ds_reg);
        r2       = b0 ? (r1 - W_DIV'(ds_reg)) : r1;
        rem_next = r2[albf_pkg::NUM_W-1:0];
        q_next   = {q_reg[albf_pkg::Q_W-3:0], b1, b0};
        ds_next  = ds_reg >> 2;
    end

    // Bin limit check on the finished quotient
    assign bin_over = (q_reg >= albf_pkg::Q_W'(cfg.bins_in_use)) || (int'(q_reg) >= BIN_DEPTH);

    // Command towards the back end
    always_comb
    begin
        cmd.kind    = kind_reg;
        cmd.reject  = rej_reg;
        cmd.bin     = q_reg;
        cmd.hit     = int'(q_reg) < BIN_DEPTH;
        cmd.dist_mm = dist_reg;
        cmd.inten   = inten_reg;
        if (kind_reg == albf_pkg::CMD_ADD && bin_over)
        begin
            cmd.kind   = albf_pkg::CMD_REJECT;
            cmd.reject = albf_pkg::ST_BIN_OUT;
        end
    end

    assign cmd_push = (state_reg == S_SEND) && !cmd_full;

    // Sequencer: accept, classify, divide, hand over
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (push && !full)
                    begin
                        func_reg  <= func;
                        ang_reg   <= a_wrap[albf_pkg::ANGLE_W-1:0];
                        dist_reg  <= point_distance_mm;
                        inten_reg <= point_intensity;
                        rbin_reg  <= read_bin;
                        state_reg <= S_GATE;
                    end
                end
                S_GATE:
                begin
                    if (func_reg)
                    begin
                        kind_reg  <= albf_pkg::CMD_READ;
                        q_reg     <= albf_pkg::Q_W'(rbin_reg);
                        state_reg <= S_SEND;
                    end
                    else if (range_out)
                    begin
                        kind_reg  <= albf_pkg::CMD_REJECT;
                        rej_reg   <= albf_pkg::ST_RANGE_OUT;
                        state_reg <= S_SEND;
                    end
                    else if (angle_out)
                    begin
                        kind_reg  <= albf_pkg::CMD_REJECT;
                        rej_reg   <= albf_pkg::ST_ANGLE_OUT;
                        state_reg <= S_SEND;
                    end
                    else if (step_zero)
                    begin
                        kind_reg  <= albf_pkg::CMD_REJECT;
                        rej_reg   <= albf_pkg::ST_BIN_OUT;
                        state_reg <= S_SEND;
                    end
                    else
                    begin
                        kind_reg  <= albf_pkg::CMD_ADD;
                        rem_reg   <= num;
                        ds_reg    <= albf_pkg::DS_W'(den) << (albf_pkg::Q_W - 2);
                        q_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= rem_next;
                    q_reg   <= q_next;
                    ds_reg  <= ds_next;
                    cnt_reg <= cnt_reg + albf_pkg::DIV_CNT_W'(1);
                    if (cnt_reg == albf_pkg::DIV_CNT_W'(albf_pkg::DIV_STEPS - 1))
                    begin
                        state_reg <= S_SEND;
                    end
                end
                S_SEND:
                begin
                    if (!cmd_full)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* design/albf_back.sv */
// Back end: clears the bin store after reset, then runs read-modify-write per store command.
// Depends on albf_pkg and albf_ram; takes commands from a queue, pushes results.
`timescale 1ns / 1ps

module albf_back #(
    parameter int BIN_DEPTH = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_empty,
    input  albf_pkg::cmd_t cmd,
    output logic           cmd_pop,
    input  logic           res_full,
    output logic           res_push,
    output albf_pkg::res_t res,
    output logic           clearing
);

    localparam int IDX_W = $clog2(BIN_DEPTH);
    localparam int ENT_W = $bits(albf_pkg::entry_t);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] clr_cnt_reg;
    albf_pkg::cmd_t   cur_reg;

    logic             start;
    logic             needs_ram;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    albf_pkg::entry_t ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;
    albf_pkg::entry_t ent;

    assign clearing  = state_reg == S_CLEAR;
    assign start     = (state_reg == S_IDLE) && !cmd_empty && !res_full;
    assign cmd_pop   = start;
    assign needs_ram = (cmd.kind == albf_pkg::CMD_ADD) ||
                       ((cmd.kind == albf_pkg::CMD_READ) && cmd.hit);
    assign ent       = albf_pkg::entry_t'(ram_rdata);

    albf_ram #(
        .WIDTH (ENT_W),
        .DEPTH (BIN_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Store access and result beat for the current state
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cur_reg.bin[IDX_W-1:0];
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = cmd.bin[IDX_W-1:0];
        res_push  = 1'b0;
        res       = '0;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (needs_ram)
                    begin
                        ram_re = 1'b1;
                    end
                    else if (cmd.kind == albf_pkg::CMD_REJECT)
                    begin
                        res_push   = 1'b1;
                        res.status = cmd.reject;
                    end
                    else
                    begin
                        // Read of a bin beyond the store: empty, nothing changes
                        res_push       = 1'b1;
                        res.status     = albf_pkg::ST_READ;
                        res.bin_number = cmd.bin[albf_pkg::OUT_BIN_W-1:0];
                    end
                end
            end
            S_EVAL:
            begin
                res_push       = 1'b1;
                res.bin_number = cur_reg.bin[albf_pkg::OUT_BIN_W-1:0];
                if (cur_reg.kind == albf_pkg::CMD_READ)
                begin
                    // Report the bin, then clear it
                    res.status = albf_pkg::ST_READ;
                    res.filled = ent.valid;
                    if (ent.valid)
                    begin
                        res.rng_mm = ent.rng_mm;
                        res.inten  = ent.inten;
                    end
                    ram_we = 1'b1;
                end
                else
                begin
                    res.filled = 1'b1;
                    if (!ent.valid || (cur_reg.dist_mm < ent.rng_mm))
                    begin
                        res.status      = ent.valid ? albf_pkg::ST_CLOSER : albf_pkg::ST_NEW;
                        res.rng_mm      = cur_reg.dist_mm;
                        res.inten       = cur_reg.inten;
                        ram_we          = 1'b1;
                        ram_wdata.valid = 1'b1;
                        ram_wdata.rng_mm = cur_reg.dist_mm;
                        ram_wdata.inten = cur_reg.inten;
                    end
                    else
                    begin
                        res.status = albf_pkg::ST_KEPT;
                        res.rng_mm = ent.rng_mm;
                        res.inten  = ent.inten;
                    end
                end
            end
            default:
            begin
                res_push = 1'b0;
            end
        endcase
    end

    // Clearing pass, then one command at a time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
                    if (clr_cnt_reg == IDX_W'(BIN_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        cur_reg <= cmd;
                        if (needs_ram)
                        begin
                            state_reg <= S_EVAL;
                        end
                    end
                end
                S_EVAL:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* design/lidar_angle_bin_min_range_fusion.sv */
// Add beat: accept, gate, 8 divider steps, hand-over; read or beat rejected at the gate:
// accept, gate, hand-over. A new beat is taken only after the last one is handed over.
// The 2-bit-per-cycle divider sets add throughput while the command queue has room.
// Back end reads the store once per bin command and writes it back unless the old entry is kept.
// Reset clears configuration to defaults; the bin store is then cleared one entry a cycle,
// with full held high. Configuration writes are taken throughout.
`timescale 1ns / 1ps

module lidar_angle_bin_min_range_fusion #(
    parameter int BIN_DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  func,
    input  logic signed [15:0]                    point_angle,
    input  logic [albf_pkg::DIST_W-1:0]           point_distance_mm,
    input  logic [albf_pkg::INTEN_W-1:0]          point_intensity,
    input  logic [albf_pkg::IN_BIN_W-1:0]         read_bin,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [albf_pkg::STATUS_W-1:0]         status,
    output logic [albf_pkg::OUT_BIN_W-1:0]        bin_number,
    output logic                                  bin_filled,
    output logic [albf_pkg::DIST_W-1:0]           bin_range_mm,
    output logic [albf_pkg::INTEN_W-1:0]          bin_intensity,
    input  logic                                  cfg_write,
    input  logic [albf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [albf_pkg::CFG_W-1:0]            cfg_data
);

    localparam int CMD_W = $bits(albf_pkg::cmd_t);
    localparam int RES_W = $bits(albf_pkg::res_t);

    albf_pkg::cfg_t cfg_reg;
    albf_pkg::cmd_t front_cmd;
    logic           cmd_push;
    logic           cmd_full;
    logic [CMD_W-1:0] cmd_dout;
    logic           cmd_empty;
    logic           cmd_pop;
    logic           res_push;
    albf_pkg::res_t back_res;
    logic           res_full;
    logic [RES_W-1:0] res_dout;
    albf_pkg::res_t out_res;
    logic           clearing;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_low     <= albf_pkg::ANGLE_LOW_RST;
            cfg_reg.angle_high    <= albf_pkg::ANGLE_HIGH_RST;
            cfg_reg.angle_step    <= albf_pkg::ANGLE_STEP_RST;
            cfg_reg.bins_in_use   <= albf_pkg::BINS_IN_USE_RST;
            cfg_reg.range_low_mm  <= albf_pkg::RANGE_LOW_RST;
            cfg_reg.range_high_mm <= albf_pkg::RANGE_HIGH_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                albf_pkg::REG_ANGLE_LOW:
                begin
                    cfg_reg.angle_low <= cfg_data[albf_pkg::ANGLE_W-1:0];
                end
                albf_pkg::REG_ANGLE_HIGH:
                begin
                    cfg_reg.angle_high <= cfg_data[albf_pkg::ANGLE_W-1:0];
                end
                albf_pkg::REG_ANGLE_STEP:
                begin
                    cfg_reg.angle_step <= cfg_data[albf_pkg::ANGLE_W-1:0];
                end
                albf_pkg::REG_BINS_IN_USE:
                begin
                    cfg_reg.bins_in_use <= cfg_data[albf_pkg::COUNT_W-1:0];
                end
                albf_pkg::REG_RANGE_LOW:
                begin
                    cfg_reg.range_low_mm <= cfg_data;
                end
                albf_pkg::REG_RANGE_HIGH:
                begin
                    cfg_reg.range_high_mm <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Front end: accept and classify
    albf_front #(
        .BIN_DEPTH (BIN_DEPTH)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .clearing          (clearing),
        .push              (push),
        .full              (full),
        .func              (func),
        .point_angle       (point_angle),
        .point_distance_mm (point_distance_mm),
        .point_intensity   (point_intensity),
        .read_bin          (read_bin),
        .cmd_push          (cmd_push),
        .cmd               (front_cmd),
        .cmd_full          (cmd_full)
    );

    // Command queue between the two halves
    albf_fifo #(
        .WIDTH (CMD_W)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (front_cmd),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .dout  (cmd_dout),
        .empty (cmd_empty)
    );

    // Back end: bin store update
    albf_back #(
        .BIN_DEPTH (BIN_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (albf_pkg::cmd_t'(cmd_dout)),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (back_res),
        .clearing  (clearing)
    );

    // Result queue towards the consumer
    albf_fifo #(
        .WIDTH (RES_W)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (back_res),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_dout),
        .empty (empty)
    );

    assign out_res       = albf_pkg::res_t'(res_dout);
    assign status        = out_res.status;
    assign bin_number    = out_res.bin_number;
    assign bin_filled    = out_res.filled;
    assign bin_range_mm  = out_res.rng_mm;
    assign bin_intensity = out_res.inten;

endmodule

/* design/albf_checker.sv */
// Port-level checks on the result side of the lidar bin fusion block.
// Depends on albf_pkg; attached to the top level by the bind below.
`timescale 1ns / 1ps

module albf_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               empty,
    input logic                               pop,
    input logic [albf_pkg::STATUS_W-1:0]      status,
    input logic [albf_pkg::OUT_BIN_W-1:0]     bin_number,
    input logic                               bin_filled,
    input logic [albf_pkg::DIST_W-1:0]        bin_range_mm,
    input logic [albf_pkg::INTEN_W-1:0]       bin_intensity
);

    // A rejected point reports no bin at all
    a_reject_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && (status == albf_pkg::ST_RANGE_OUT || status == albf_pkg::ST_ANGLE_OUT ||
                    status == albf_pkg::ST_BIN_OUT))
        |-> (bin_number == '0 && !bin_filled && bin_range_mm == '0 && bin_intensity == '0)
    ) else $error("rejected point carries bin data");

    // An accepted point always leaves its bin filled
    a_add_filled: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && (status == albf_pkg::ST_NEW || status == albf_pkg::ST_CLOSER ||
                    status == albf_pkg::ST_KEPT))
        |-> bin_filled
    ) else $error("accepted point reports an empty bin");

    // Reading an empty bin returns zero range and intensity
    a_empty_read: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && status == albf_pkg::ST_READ && !bin_filled)
        |-> (bin_range_mm == '0 && bin_intensity == '0)
    ) else $error("empty bin read returns stale data");

    // A waiting result beat holds until it is taken
    a_result_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && !pop)
        |=> (!empty && $stable(status) && $stable(bin_number) && $stable(bin_filled) &&
             $stable(bin_range_mm) && $stable(bin_intensity))
    ) else $error("result beat changed while stalled");

endmodule

bind lidar_angle_bin_min_range_fusion albf_checker u_albf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .status        (status),
    .bin_number    (bin_number),
    .bin_filled    (bin_filled),
    .bin_range_mm  (bin_range_mm),
    .bin_intensity (bin_intensity)
);
